>>> hw/rtl/pbnf_pkg.sv
// Shared types and constants of the page bitmap next-fit allocator.
// Depends on nothing; pbnf_csr, pbnf_engine, the top level and the testbench refer to it by scoped names.
package pbnf_pkg;

   // Field widths of the channels and the register port
   localparam int PAGE_W     = 24;
   localparam int COUNT_W    = 13;
   localparam int STATUS_W   = 2;
   localparam int REGION_W   = 2;
   localparam int WORD_BITS  = 32;
   localparam int BIT_W      = 5;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_INDEX_W = 3;

   localparam logic [WORD_BITS-1:0] FULL_WORD = 32'hffff_ffff;

   // Request actions
   localparam logic ACTION_ALLOC = 1'b0;
   localparam logic ACTION_FREE  = 1'b1;

   // Register kind, low bit of the register index
   localparam logic CSR_KIND_BASE  = 1'b0;
   localparam logic CSR_KIND_PAGES = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK           = 2'd0,
      STATUS_NO_MEMORY    = 2'd1,
      STATUS_OUTSIDE      = 2'd2,
      STATUS_ALREADY_FREE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_ALLOC_WR,
      ST_FREE_CHK,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic                action;
      logic [REGION_W-1:0] region;
      logic [PAGE_W-1:0]   page_in;
   } req_type;

   typedef struct packed {
      logic [PAGE_W-1:0]   page_out;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  avail_pages;
   } rsp_type;

   // Region (re)initialization, raised in the cycle a page count is written
   typedef struct packed {
      logic                init;
      logic [REGION_W-1:0] region;
      logic [COUNT_W-1:0]  pages;
   } cfg_event_type;

   typedef struct packed {
      logic sweeping;
      logic scanning;
   } eng_status_type;

endpackage

>>> hw/rtl/pbnf_stream_if.sv
// Valid/ready stream channel used for the request and response sides.
// The payload type is a parameter; the allocator uses pbnf_pkg::req_type / rsp_type.
interface pbnf_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/pbnf_ram.sv
// Generic single write port, single read port RAM with a registered read.
// Depends on nothing.
module pbnf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/pbnf_csr.sv
// APB-style register file: base page and page count of each region.
// Depends on pbnf_pkg; raises a region init event when a page count is written.
module pbnf_csr #(
   parameter int REGION_COUNT     = 4,
   parameter int MAX_REGION_PAGES = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [pbnf_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [pbnf_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [pbnf_pkg::CSR_DATA_W-1:0] prdata,
   output logic [pbnf_pkg::PAGE_W-1:0]     base_page [REGION_COUNT],
   output logic [pbnf_pkg::COUNT_W-1:0]    region_pages [REGION_COUNT],
   output pbnf_pkg::cfg_event_type         cfg_event
);

   localparam int RW = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;

   logic [pbnf_pkg::PAGE_W-1:0]      base_ff  [REGION_COUNT];
   logic [pbnf_pkg::COUNT_W-1:0]     pages_ff [REGION_COUNT];
   logic [pbnf_pkg::CSR_INDEX_W-1:0] index;
   logic [pbnf_pkg::REGION_W-1:0]    reg_region;
   logic                             reg_kind;
   logic                             region_ok;
   logic [RW-1:0]                    rsel;
   logic                             wr_strobe;
   logic [pbnf_pkg::COUNT_W-1:0]     pages_raw;
   logic [pbnf_pkg::COUNT_W-1:0]     pages_sat;

   // Address decode: index = paddr / 4, region = index / 2, kind = index bit 0
   assign index      = paddr[pbnf_pkg::CSR_ADDR_W-1:2];
   assign reg_region = index[pbnf_pkg::CSR_INDEX_W-1:1];
   assign reg_kind   = index[0];
   assign region_ok  = (32'(reg_region) < REGION_COUNT);
   assign rsel       = RW'(reg_region);
   assign wr_strobe  = psel & penable & pwrite;

   // Page count saturates at the region capacity
   assign pages_raw = pwdata[pbnf_pkg::COUNT_W-1:0];
   always_comb begin
      pages_sat = pages_raw;
      if (32'(pages_raw) > MAX_REGION_PAGES) begin
         pages_sat = pbnf_pkg::COUNT_W'(MAX_REGION_PAGES);
      end
   end

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < REGION_COUNT; r++) begin
            base_ff[r]  <= '0;
            pages_ff[r] <= '0;
         end
      end else if (wr_strobe && region_ok) begin
         if (reg_kind == pbnf_pkg::CSR_KIND_BASE) begin
            base_ff[rsel] <= pwdata[pbnf_pkg::PAGE_W-1:0];
         end else begin
            pages_ff[rsel] <= pages_sat;
         end
      end
   end

   // Read mux
   always_comb begin
      prdata = '0;
      if (region_ok) begin
         if (reg_kind == pbnf_pkg::CSR_KIND_BASE) begin
            prdata = pbnf_pkg::CSR_DATA_W'(base_ff[rsel]);
         end else begin
            prdata = pbnf_pkg::CSR_DATA_W'(pages_ff[rsel]);
         end
      end
   end

   // Init event toward the engine
   assign cfg_event.init   = wr_strobe && region_ok && (reg_kind == pbnf_pkg::CSR_KIND_PAGES);
   assign cfg_event.region = reg_region;
   assign cfg_event.pages  = pages_sat;

   assign base_page    = base_ff;
   assign region_pages = pages_ff;

endmodule

>>> hw/rtl/pbnf_engine.sv
// Allocation engine: bitmap RAM, next-fit scan, free check and the clearing pass.
// Depends on pbnf_pkg and pbnf_ram; region settings come from pbnf_csr.
module pbnf_engine #(
   parameter int REGION_COUNT     = 4,
   parameter int MAX_REGION_PAGES = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  pbnf_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output pbnf_pkg::rsp_type            rsp_data,
   input  logic [pbnf_pkg::PAGE_W-1:0]  base_page [REGION_COUNT],
   input  logic [pbnf_pkg::COUNT_W-1:0] region_pages [REGION_COUNT],
   input  pbnf_pkg::cfg_event_type      cfg_event,
   output pbnf_pkg::eng_status_type     eng_status
);

   localparam int WORDS = (MAX_REGION_PAGES + pbnf_pkg::WORD_BITS - 1) / pbnf_pkg::WORD_BITS;
   localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int WCW   = $clog2(WORDS + 1);
   localparam int RW    = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
   localparam int AW    = RW + WW;
   localparam int DEPTH = 1 << AW;
   localparam int LOW   = WW + pbnf_pkg::BIT_W;
   localparam int CMPW  = ((LOW > pbnf_pkg::COUNT_W) ? LOW : pbnf_pkg::COUNT_W) + 1;
   localparam int LIMW  = pbnf_pkg::PAGE_W + 1;

   // Control and per-region state
   pbnf_pkg::state_type          state_ff, state_in;
   pbnf_pkg::req_type            item_ff, item_in;
   logic [WW-1:0]                scan_ptr_ff [REGION_COUNT];
   logic [WW-1:0]                scan_ptr_in [REGION_COUNT];
   logic [pbnf_pkg::COUNT_W-1:0] free_cnt_ff [REGION_COUNT];
   logic [pbnf_pkg::COUNT_W-1:0] free_cnt_in [REGION_COUNT];
   logic [REGION_COUNT-1:0]      pending_ff, pending_in;
   logic [WW-1:0]                sweep_w_ff, sweep_w_in;

   // Scan datapath
   logic [WW-1:0]                    cur_w_ff, cur_w_in;
   logic [WCW-1:0]                   cnt_ff, cnt_in;
   logic [pbnf_pkg::BIT_W-1:0]       bit_ff, bit_in;
   logic [pbnf_pkg::WORD_BITS-1:0]   word_ff, word_in;
   logic [pbnf_pkg::WORD_BITS-1:0]   avail_ff, avail_in;
   logic [pbnf_pkg::PAGE_W-1:0]      res_page_ff, res_page_in;
   logic [pbnf_pkg::STATUS_W-1:0]    res_status_ff, res_status_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   pbnf_pkg::rsp_type                rsp_data_ff, rsp_data_in;

   // RAM port
   logic                           mem_we;
   logic [AW-1:0]                  mem_waddr, mem_raddr;
   logic [pbnf_pkg::WORD_BITS-1:0] mem_wdata, mem_rdata;
   logic                           eng_we;
   logic [pbnf_pkg::WORD_BITS-1:0] eng_wdata;

   // Region selection
   logic                         region_ok;
   logic [RW-1:0]                rsel;
   logic [pbnf_pkg::PAGE_W-1:0]  base_sel;
   logic [pbnf_pkg::COUNT_W-1:0] pages_sel;
   logic [pbnf_pkg::COUNT_W-1:0] free_sel;
   logic [WW-1:0]                ptr_sel;
   logic [WCW-1:0]               words;

   // Combinational helpers
   logic                           sweeping;
   logic [RW-1:0]                  sweep_r;
   logic                           sweep_found;
   logic [LIMW-1:0]                limit;
   logic                           outside;
   logic [pbnf_pkg::PAGE_W-1:0]    offset;
   logic [pbnf_pkg::COUNT_W-1:0]   idx;
   logic [WW-1:0]                  free_word;
   logic [CMPW-1:0]                lo, sz;
   logic [pbnf_pkg::WORD_BITS-1:0] vmask, avail, part_mask, lsb;
   logic [WW-1:0]                  next_w;
   logic                           last_word;
   logic [pbnf_pkg::BIT_W-1:0]     alloc_bit;
   logic                           can_load;
   logic                           bit_set;

   pbnf_ram #(
      .WIDTH (pbnf_pkg::WORD_BITS),
      .DEPTH (DEPTH)
   ) u_bitmap (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // Region of the current item
   assign region_ok = (32'(item_ff.region) < REGION_COUNT);
   assign rsel      = RW'(item_ff.region);
   assign base_sel  = region_ok ? base_page[rsel]    : '0;
   assign pages_sel = region_ok ? region_pages[rsel] : '0;
   assign free_sel  = region_ok ? free_cnt_ff[rsel]  : '0;
   assign ptr_sel   = region_ok ? scan_ptr_ff[rsel]  : '0;
   assign words     = WCW'(({1'b0, pages_sel} + (pbnf_pkg::COUNT_W + 1)'(pbnf_pkg::WORD_BITS - 1))
                           >> pbnf_pkg::BIT_W);

   // Clearing pass: lowest region still waiting to be zeroed
   assign sweeping = |pending_ff;
   always_comb begin
      sweep_r     = '0;
      sweep_found = 1'b0;
      for (int r = 0; r < REGION_COUNT; r++) begin
         if (pending_ff[r] && !sweep_found) begin
            sweep_r     = RW'(r);
            sweep_found = 1'b1;
         end
      end
   end

   // Free request range check and word/bit split
   assign limit     = LIMW'(base_sel) + LIMW'(pages_sel);
   assign outside   = !region_ok || (item_ff.page_in < base_sel)
                      || (LIMW'(item_ff.page_in) >= limit);
   assign offset    = item_ff.page_in - base_sel;
   assign idx       = offset[pbnf_pkg::COUNT_W-1:0];
   assign free_word = WW'(idx >> pbnf_pkg::BIT_W);

   // Valid-page mask of the scanned word; bits past the region end never count
   assign lo        = CMPW'({cur_w_ff, {pbnf_pkg::BIT_W{1'b0}}});
   assign sz        = CMPW'(pages_sel);
   assign part_mask = (32'd1 << pbnf_pkg::BIT_W'(sz - lo)) - 32'd1;
   always_comb begin
      if ((lo + CMPW'(pbnf_pkg::WORD_BITS)) <= sz) begin
         vmask = pbnf_pkg::FULL_WORD;
      end else if (lo >= sz) begin
         vmask = '0;
      end else begin
         vmask = part_mask;
      end
   end
   assign avail     = ~mem_rdata & vmask;
   assign next_w    = ((WCW'(cur_w_ff) + WCW'(1)) == words) ? '0 : cur_w_ff + WW'(1);
   assign last_word = ((cnt_ff + WCW'(1)) == words);

   // Lowest free bit of the found word: isolate, then encode
   assign lsb = avail_ff & (~avail_ff + 32'd1);
   always_comb begin
      alloc_bit = '0;
      for (int b = 0; b < pbnf_pkg::WORD_BITS; b++) begin
         if (lsb[b]) begin
            alloc_bit = alloc_bit | pbnf_pkg::BIT_W'(b);
         end
      end
   end

   assign bit_set  = mem_rdata[bit_ff];
   assign can_load = !rsp_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pbnf_pkg::ST_IDLE: begin
            if (req_valid && req_ready) begin
               state_in = pbnf_pkg::ST_CHECK;
            end
         end
         pbnf_pkg::ST_CHECK: begin
            if (item_ff.action == pbnf_pkg::ACTION_ALLOC) begin
               if (!region_ok || free_sel == '0 || words == '0) begin
                  state_in = pbnf_pkg::ST_RESP;
               end else begin
                  state_in = pbnf_pkg::ST_SCAN;
               end
            end else if (outside) begin
               state_in = pbnf_pkg::ST_RESP;
            end else begin
               state_in = pbnf_pkg::ST_FREE_CHK;
            end
         end
         pbnf_pkg::ST_SCAN: begin
            if (avail != '0) begin
               state_in = pbnf_pkg::ST_ALLOC_WR;
            end else if (last_word) begin
               state_in = pbnf_pkg::ST_RESP;
            end
         end
         pbnf_pkg::ST_ALLOC_WR: state_in = pbnf_pkg::ST_RESP;
         pbnf_pkg::ST_FREE_CHK: state_in = pbnf_pkg::ST_RESP;
         pbnf_pkg::ST_RESP: begin
            if (can_load) begin
               state_in = pbnf_pkg::ST_IDLE;
            end
         end
         default: state_in = pbnf_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs per state
   always_comb begin
      item_in       = item_ff;
      cur_w_in      = cur_w_ff;
      cnt_in        = cnt_ff;
      bit_in        = bit_ff;
      word_in       = word_ff;
      avail_in      = avail_ff;
      res_page_in   = res_page_ff;
      res_status_in = res_status_ff;
      scan_ptr_in   = scan_ptr_ff;
      free_cnt_in   = free_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      eng_we        = 1'b0;
      eng_wdata     = '0;
      mem_raddr     = {rsel, cur_w_ff};
      unique case (state_ff)
         pbnf_pkg::ST_IDLE: begin
            if (req_valid && req_ready) begin
               item_in = req_data;
            end
         end
         pbnf_pkg::ST_CHECK: begin
            res_page_in = '0;
            cnt_in      = '0;
            if (item_ff.action == pbnf_pkg::ACTION_ALLOC) begin
               res_status_in = pbnf_pkg::STATUS_NO_MEMORY;
               cur_w_in      = ptr_sel;
               mem_raddr     = {rsel, ptr_sel};
            end else begin
               res_status_in = pbnf_pkg::STATUS_OUTSIDE;
               cur_w_in      = free_word;
               bit_in        = idx[pbnf_pkg::BIT_W-1:0];
               mem_raddr     = {rsel, free_word};
            end
         end
         pbnf_pkg::ST_SCAN: begin
            // check the word read last cycle, fetch the next one
            mem_raddr = {rsel, next_w};
            if (avail != '0) begin
               avail_in = avail;
               word_in  = mem_rdata;
            end else begin
               cur_w_in = next_w;
               cnt_in   = cnt_ff + WCW'(1);
            end
         end
         pbnf_pkg::ST_ALLOC_WR: begin
            eng_we             = 1'b1;
            eng_wdata          = word_ff | lsb;
            scan_ptr_in[rsel]  = cur_w_ff;
            free_cnt_in[rsel]  = free_cnt_ff[rsel] - pbnf_pkg::COUNT_W'(1);
            res_status_in      = pbnf_pkg::STATUS_OK;
            res_page_in        = base_sel + pbnf_pkg::PAGE_W'({cur_w_ff, alloc_bit});
         end
         pbnf_pkg::ST_FREE_CHK: begin
            if (bit_set) begin
               eng_we            = 1'b1;
               eng_wdata         = mem_rdata & ~(32'd1 << bit_ff);
               free_cnt_in[rsel] = free_cnt_ff[rsel] + pbnf_pkg::COUNT_W'(1);
               res_status_in     = pbnf_pkg::STATUS_OK;
            end else begin
               res_status_in     = pbnf_pkg::STATUS_ALREADY_FREE;
            end
         end
         pbnf_pkg::ST_RESP: begin
            if (can_load) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.page_out    = res_page_ff;
               rsp_data_in.status      = res_status_ff;
               rsp_data_in.avail_pages = free_sel;
            end
         end
         default: begin
            item_in = item_ff;
         end
      endcase

      // Region init from the register port wins over engine updates
      if (cfg_event.init) begin
         scan_ptr_in[RW'(cfg_event.region)] = '0;
         free_cnt_in[RW'(cfg_event.region)] = cfg_event.pages;
      end
   end

   // Clearing pass bookkeeping
   always_comb begin
      pending_in = pending_ff;
      sweep_w_in = sweep_w_ff;
      if (sweeping) begin
         if (sweep_w_ff == WW'(WORDS - 1)) begin
            sweep_w_in          = '0;
            pending_in[sweep_r] = 1'b0;
         end else begin
            sweep_w_in = sweep_w_ff + WW'(1);
         end
      end
      if (cfg_event.init) begin
         pending_in[RW'(cfg_event.region)] = 1'b1;
      end
   end

   // RAM write port: the clearing pass owns it while running
   assign mem_we    = sweeping ? 1'b1 : eng_we;
   assign mem_waddr = sweeping ? {sweep_r, sweep_w_ff} : {rsel, cur_w_ff};
   assign mem_wdata = sweeping ? '0 : eng_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pbnf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pending_ff   <= '1;
         sweep_w_ff   <= '0;
         for (int r = 0; r < REGION_COUNT; r++) begin
            scan_ptr_ff[r] <= '0;
            free_cnt_ff[r] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pending_ff   <= pending_in;
         sweep_w_ff   <= sweep_w_in;
         scan_ptr_ff  <= scan_ptr_in;
         free_cnt_ff  <= free_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      cur_w_ff      <= cur_w_in;
      cnt_ff        <= cnt_in;
      bit_ff        <= bit_in;
      word_ff       <= word_in;
      avail_ff      <= avail_in;
      res_page_ff   <= res_page_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // One item at a time: its write lands before the next item can read
   assign req_ready           = (state_ff == pbnf_pkg::ST_IDLE) && !sweeping;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data            = rsp_data_ff;
   assign eng_status.sweeping = sweeping;
   assign eng_status.scanning = (state_ff == pbnf_pkg::ST_SCAN);

endmodule

>>> hw/rtl/page_bitmap_next_fit_allocator.sv
// Top level of the page bitmap next-fit allocator.
// Depends on pbnf_pkg, pbnf_stream_if, pbnf_csr and pbnf_engine.
//
// Usage:
//  - req_chan carries {action, region, page_in}; rsp_chan returns one
//    {page_out, status, avail_pages} for every request, in order.
//  - csr_* is an APB-style port: region r base page at byte 8*r, page count
//    at 8*r+4. Writing a page count frees every page of that region.
//  - States: a free passes through CHECK, FREE_CHK and RESP, skipping
//    FREE_CHK when the page lies outside the region; an allocate on a
//    region with no free page goes from CHECK to RESP. Otherwise an allocate
//    runs CHECK, SCAN over k bitmap words (1 up to the region's word count),
//    ALLOC_WR and RESP; the scan reads one word per cycle from the RAM.
//  - Requests are handled one at a time; the response sits in an output
//    register, so the next request is taken while a result waits. If the
//    receiver stalls with a result still waiting, the engine holds its
//    next result until the register drains.
//  - Reset clears the bitmap RAM one word per cycle, all REGION_COUNT *
//    ceil(MAX_REGION_PAGES/32) words, while no request is taken. A page
//    count write clears that region the same way.
module page_bitmap_next_fit_allocator #(
   parameter int REGION_COUNT     = 4,
   parameter int MAX_REGION_PAGES = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   pbnf_stream_if.sink                     req_chan,
   pbnf_stream_if.source                   rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [pbnf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [pbnf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [pbnf_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   logic [pbnf_pkg::PAGE_W-1:0]  base_page    [REGION_COUNT];
   logic [pbnf_pkg::COUNT_W-1:0] region_pages [REGION_COUNT];
   pbnf_pkg::cfg_event_type      cfg_event;
   pbnf_pkg::eng_status_type     eng_status;
   logic                         req_ready;

   assign csr_pready = 1'b1;

   pbnf_csr #(
      .REGION_COUNT     (REGION_COUNT),
      .MAX_REGION_PAGES (MAX_REGION_PAGES)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (csr_psel),
      .penable      (csr_penable),
      .pwrite       (csr_pwrite),
      .paddr        (csr_paddr),
      .pwdata       (csr_pwdata),
      .prdata       (csr_prdata),
      .base_page    (base_page),
      .region_pages (region_pages),
      .cfg_event    (cfg_event)
   );

   pbnf_engine #(
      .REGION_COUNT     (REGION_COUNT),
      .MAX_REGION_PAGES (MAX_REGION_PAGES)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_chan.valid),
      .req_ready    (req_ready),
      .req_data     (req_chan.payload),
      .rsp_valid    (rsp_chan.valid),
      .rsp_ready    (rsp_chan.ready),
      .rsp_data     (rsp_chan.payload),
      .base_page    (base_page),
      .region_pages (region_pages),
      .cfg_event    (cfg_event),
      .eng_status   (eng_status)
   );

   assign req_chan.ready = req_ready;

   // A page count write starts a clearing pass right away
   a_init_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      cfg_event.init |=> eng_status.sweeping)
      else $error("region init did not start a clearing pass");

   // No request transfer while the bitmap is being cleared
   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |-> !eng_status.sweeping)
      else $error("request taken during clearing pass");

   // Checks that the scan never runs alongside a clearing pass
   a_no_scan_in_sweep: assert property (@(posedge clock) disable iff (reset)
      eng_status.scanning |-> !eng_status.sweeping)
      else $error("bitmap scan during clearing pass");

   // No page number on a failed or free response
   a_fail_page_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.payload.status != pbnf_pkg::STATUS_OK))
      |-> (rsp_chan.payload.page_out == '0))
      else $error("failed response carries a page number");

endmodule

>>> test/page_bitmap_next_fit_allocator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the page bitmap next-fit allocator: a driver and monitor
// on the stream channels, APB register setup, and a bit-accurate model of the bitmaps.
// Depends on pbnf_pkg, pbnf_stream_if and page_bitmap_next_fit_allocator.
module page_bitmap_next_fit_allocator_tb;

   localparam int CLOCK_PERIOD     = 12;
   localparam int REGION_COUNT     = 4;
   localparam int MAX_REGION_PAGES = 4096;
   localparam int WORDS_PER_REGION = MAX_REGION_PAGES / pbnf_pkg::WORD_BITS;
   localparam int RESET_SWEEP      = 540;   // bitmap clear after reset
   localparam int REGION_SWEEP     = 140;   // region clear after a page count write
   localparam int DRAIN_CYCLES     = 200;
   localparam int TIMEOUT_CYCLES   = 1_500_000;
   localparam int IDLE_PERCENT     = 15;
   localparam int CALM_FIRST       = 1100;  // transfers with no random idling
   localparam int CALM_LAST        = 1300;
   localparam int HOLD_AT_RESULT   = 700;
   localparam int HOLD_CYCLES      = 400;
   localparam int MAX_REPORTS      = 10;

   logic                            clock;
   logic                            reset;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [pbnf_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [pbnf_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [pbnf_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   pbnf_stream_if #(.payload_type(pbnf_pkg::req_type)) req_if ();
   pbnf_stream_if #(.payload_type(pbnf_pkg::rsp_type)) rsp_if ();

   page_bitmap_next_fit_allocator #(
      .REGION_COUNT    (REGION_COUNT),
      .MAX_REGION_PAGES(MAX_REGION_PAGES)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_if),
      .rsp_chan   (rsp_if),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // Model of the allocator state
   logic [pbnf_pkg::WORD_BITS-1:0] page_map [REGION_COUNT][WORDS_PER_REGION];
   int unsigned                    scan_word [REGION_COUNT];
   int unsigned                    free_left [REGION_COUNT];
   int unsigned                    region_base [REGION_COUNT];
   int unsigned                    region_size [REGION_COUNT];

   pbnf_pkg::req_type pending_requests[$];
   pbnf_pkg::rsp_type awaited_results[$];
   pbnf_pkg::req_type held_frees[$];     // frees of pages the block handed out
   int unsigned       accepted_count;
   int unsigned       results_seen;
   int unsigned       mismatch_count;
   logic              rsp_hold;
   pbnf_pkg::rsp_type seen_result;
   pbnf_pkg::rsp_type wanted_result;
   pbnf_pkg::rsp_type predicted;

   // Clock
   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Run limit
   initial begin
      #(64'(TIMEOUT_CYCLES) * CLOCK_PERIOD);
      $display("page_bitmap_next_fit_allocator_tb: done, errors");
      $finish;
   end

   // Expected outcome of one request; updates the model state
   function automatic pbnf_pkg::rsp_type frame_outcome(pbnf_pkg::req_type rq);
      pbnf_pkg::rsp_type              res;
      int unsigned                    r;
      int unsigned                    size;
      int unsigned                    words;
      int unsigned                    w;
      int unsigned                    lo;
      int unsigned                    slot;
      int unsigned                    idx;
      logic [pbnf_pkg::WORD_BITS-1:0] usable;
      logic [pbnf_pkg::WORD_BITS-1:0] avail;
      bit                             found;
      r = rq.region;
      size = region_size[r];
      res = '0;
      found = 1'b0;
      if (rq.action == pbnf_pkg::ACTION_ALLOC) begin
         res.status = pbnf_pkg::STATUS_NO_MEMORY;
         words = (size + pbnf_pkg::WORD_BITS - 1) / pbnf_pkg::WORD_BITS;
         if (free_left[r] != 0 && words != 0) begin
            for (int i = 0; i < int'(words) && !found; i++) begin
               w = (scan_word[r] + i) % words;
               lo = w * pbnf_pkg::WORD_BITS;
               // bits past the region's end never count as free
               usable = (lo + pbnf_pkg::WORD_BITS <= size) ? pbnf_pkg::FULL_WORD
                        : (32'd1 << (size - lo)) - 32'd1;
               avail = ~page_map[r][w] & usable;
               if (avail != '0) begin
                  slot = 0;
                  while (!avail[slot]) slot++;
                  page_map[r][w][slot] = 1'b1;
                  scan_word[r] = w;
                  free_left[r]--;
                  res.page_out = pbnf_pkg::PAGE_W'(region_base[r] + lo + slot);
                  res.status = pbnf_pkg::STATUS_OK;
                  found = 1'b1;
               end
            end
         end
      end else if (32'(rq.page_in) < region_base[r] ||
                   32'(rq.page_in) >= region_base[r] + size) begin
         res.status = pbnf_pkg::STATUS_OUTSIDE;
      end else begin
         idx = 32'(rq.page_in) - region_base[r];
         w = idx / pbnf_pkg::WORD_BITS;
         slot = idx % pbnf_pkg::WORD_BITS;
         if (!page_map[r][w][slot]) begin
            res.status = pbnf_pkg::STATUS_ALREADY_FREE;
         end else begin
            page_map[r][w][slot] = 1'b0;
            free_left[r]++;
            res.status = pbnf_pkg::STATUS_OK;
         end
      end
      res.avail_pages = pbnf_pkg::COUNT_W'(free_left[r]);
      return res;
   endfunction

   function automatic void note_mismatch(string what, pbnf_pkg::rsp_type want,
                                         pbnf_pkg::rsp_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t mismatch (%s): expected page %h status %0d free %0d, %s",
                  $time, what, want.page_out, want.status, want.avail_pages,
                  $sformatf("got page %h status %0d free %0d",
                            got.page_out, got.status, got.avail_pages));
   endfunction

   // Request driver: one transfer per accepted item, prediction at acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.payload <= '0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predicted = frame_outcome(req_if.payload);
            awaited_results.push_back(predicted);
            accepted_count++;
            if (req_if.payload.action == pbnf_pkg::ACTION_ALLOC &&
                predicted.status == pbnf_pkg::STATUS_OK)
               held_frees.push_back('{pbnf_pkg::ACTION_FREE, req_if.payload.region,
                                      predicted.page_out});
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_requests.size() != 0 &&
                !(!(accepted_count >= CALM_FIRST && accepted_count < CALM_LAST) &&
                  $urandom_range(99) < IDLE_PERCENT)) begin
               req_if.valid <= 1'b1;
               req_if.payload <= pending_requests.pop_front();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compare each transfer with the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            seen_result = rsp_if.payload;
            results_seen++;
            if (awaited_results.size() == 0) begin
               note_mismatch("nothing awaited", '0, seen_result);
            end else begin
               wanted_result = awaited_results.pop_front();
               if (seen_result.page_out !== wanted_result.page_out ||
                   seen_result.status !== wanted_result.status ||
                   seen_result.avail_pages !== wanted_result.avail_pages)
                  note_mismatch("wrong fields", wanted_result, seen_result);
            end
         end
         rsp_if.ready <= !(rsp_hold ||
                           (!(accepted_count >= CALM_FIRST && accepted_count < CALM_LAST) &&
                            $urandom_range(99) < IDLE_PERCENT));
      end
   end

   // Long receiver hold-off so the block backs up into its input
   initial begin
      rsp_hold = 1'b0;
      while (results_seen < HOLD_AT_RESULT) @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   task automatic queue_request(input logic action, input int unsigned region,
                                input int unsigned page);
      pending_requests.push_back('{action, pbnf_pkg::REGION_W'(region),
                                   pbnf_pkg::PAGE_W'(page)});
   endtask

   // Waits until every queued item is sent and every result has come back
   task automatic wait_quiet();
      do @(posedge clock);
      while (pending_requests.size() != 0 || req_if.valid || awaited_results.size() != 0);
   endtask

   // APB write; the model follows the register at the access edge
   task automatic csr_write(input int unsigned index,
                            input logic [pbnf_pkg::CSR_DATA_W-1:0] value);
      int unsigned r;
      int unsigned count;
      r = index / 2;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= pbnf_pkg::CSR_ADDR_W'(index * 4);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (index[0] == pbnf_pkg::CSR_KIND_BASE) begin
         region_base[r] = 32'(value[pbnf_pkg::PAGE_W-1:0]);
      end else begin
         count = 32'(value[pbnf_pkg::COUNT_W-1:0]);
         if (count > MAX_REGION_PAGES) count = MAX_REGION_PAGES;
         region_size[r] = count;
         scan_word[r] = 0;
         free_left[r] = count;
         for (int w = 0; w < WORDS_PER_REGION; w++) page_map[r][w] = '0;
         // the block clears the region bitmap one word per cycle
         repeat (REGION_SWEEP) @(posedge clock);
      end
   endtask

   task automatic program_region(input int unsigned r, input int unsigned base,
                                 input int unsigned pages);
      csr_write(2 * r + pbnf_pkg::CSR_KIND_BASE, pbnf_pkg::CSR_DATA_W'(base));
      csr_write(2 * r + pbnf_pkg::CSR_KIND_PAGES, pbnf_pkg::CSR_DATA_W'(pages));
   endtask

   // Mostly well-formed traffic: allocations and frees of pages handed out,
   // with some in-region frees at random and some raw noise
   function automatic pbnf_pkg::req_type make_request();
      pbnf_pkg::req_type rq;
      int unsigned       roll;
      int unsigned       pick;
      int unsigned       r;
      roll = $urandom_range(99);
      rq.action = pbnf_pkg::ACTION_ALLOC;
      rq.region = pbnf_pkg::REGION_W'($urandom_range(REGION_COUNT - 1));
      rq.page_in = pbnf_pkg::PAGE_W'($urandom);
      r = rq.region;
      if (roll < 45) begin
         rq.action = pbnf_pkg::ACTION_ALLOC;
      end else if (roll < 80 && held_frees.size() != 0) begin
         pick = $urandom_range(held_frees.size() - 1);
         rq = held_frees[pick];
         held_frees.delete(pick);
      end else if (roll < 95) begin
         rq.action = pbnf_pkg::ACTION_FREE;
         rq.page_in = pbnf_pkg::PAGE_W'(region_base[r] +
                         (region_size[r] != 0 ? $urandom_range(region_size[r] - 1) : 0));
      end else begin
         rq.action = 1'($urandom_range(1));
      end
      return rq;
   endfunction

   task automatic feed_random(input int unsigned count);
      for (int unsigned k = 0; k < count; k++) begin
         while (pending_requests.size() >= 4) @(posedge clock);
         pending_requests.push_back(make_request());
      end
   endtask

   // Stimulus and end of run
   initial begin
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      accepted_count = 0;
      results_seen = 0;
      mismatch_count = 0;
      for (int r = 0; r < REGION_COUNT; r++) begin
         region_base[r] = 0;
         region_size[r] = 0;
         scan_word[r] = 0;
         free_left[r] = 0;
         for (int w = 0; w < WORDS_PER_REGION; w++) page_map[r][w] = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (RESET_SWEEP) @(posedge clock);

      // Registers at reset: every region empty
      queue_request(pbnf_pkg::ACTION_ALLOC, 0, 24'h0);
      queue_request(pbnf_pkg::ACTION_FREE, 3, 24'h0);
      queue_request(pbnf_pkg::ACTION_FREE, 1, 24'hffffff);
      wait_quiet();

      // Full region, wrapping partial region, single page, saturated size
      program_region(0, 24'h0, MAX_REGION_PAGES);
      program_region(1, 24'hfffffe, 3);
      program_region(2, 1000, 1);
      program_region(3, 24'h123456, 8191);
      held_frees.delete();

      queue_request(pbnf_pkg::ACTION_ALLOC, 2, 24'hffffff);
      queue_request(pbnf_pkg::ACTION_ALLOC, 2, 24'h0);        // region full
      queue_request(pbnf_pkg::ACTION_FREE, 2, 1000);          // first page
      queue_request(pbnf_pkg::ACTION_FREE, 2, 1000);          // double free
      queue_request(pbnf_pkg::ACTION_FREE, 2, 999);
      queue_request(pbnf_pkg::ACTION_FREE, 2, 1001);
      queue_request(pbnf_pkg::ACTION_ALLOC, 1, 24'h0);
      queue_request(pbnf_pkg::ACTION_ALLOC, 1, 24'h0);
      queue_request(pbnf_pkg::ACTION_ALLOC, 1, 24'h0);        // page number wraps to zero
      queue_request(pbnf_pkg::ACTION_ALLOC, 1, 24'h0);        // tail bits are not free
      queue_request(pbnf_pkg::ACTION_FREE, 1, 24'hffffff);
      queue_request(pbnf_pkg::ACTION_FREE, 1, 24'h0);         // below base after the wrap
      queue_request(pbnf_pkg::ACTION_ALLOC, 0, 24'h0);
      queue_request(pbnf_pkg::ACTION_FREE, 0, 4095);
      queue_request(pbnf_pkg::ACTION_FREE, 0, 0);
      queue_request(pbnf_pkg::ACTION_FREE, 0, 4096);
      queue_request(pbnf_pkg::ACTION_ALLOC, 0, 24'h0);
      queue_request(pbnf_pkg::ACTION_ALLOC, 3, 24'h0);
      queue_request(pbnf_pkg::ACTION_FREE, 3, 24'h123456 + 4095);
      queue_request(pbnf_pkg::ACTION_FREE, 3, 24'h123456 + 4096);
      feed_random(500);
      wait_quiet();

      // Small regions that fill up, one empty, one at the top of the page space
      program_region(0, 24'hffffff, 33);
      program_region(1, 24'h0, 0);
      program_region(2, 24'h800000, 300);
      program_region(3, $urandom_range(24'hffffff), 64);
      held_frees.delete();
      feed_random(250);
      wait_quiet();
      feed_random(250);
      wait_quiet();

      // Random bases, one full-size region for long scans
      program_region(0, $urandom_range(24'hffffff), MAX_REGION_PAGES);
      for (int unsigned r = 1; r < REGION_COUNT; r++)
         program_region(r, $urandom_range(24'hffffff), $urandom_range(1, 96));
      held_frees.delete();
      feed_random(450);

      wait_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("page_bitmap_next_fit_allocator_tb: done, clean");
      else
         $display("page_bitmap_next_fit_allocator_tb: done, errors");
      $finish;
   end

endmodule
